[src/bresenham_line_rasterizer_assert.svh]
// Assertion macros for the line rasterizer checker
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// checked only out of reset
`define BRL_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("brl check failed");

// checked through reset as well
`define BRL_CHECK_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("brl reset check failed");

`endif

[src/brl_pkg.sv]
// Shared types and constants of the line rasterizer
`default_nettype none

package brl_pkg;

  localparam int COORD_W     = 6;
  localparam int COLOR_W     = 8;
  localparam int DEC_W       = 10;
  localparam int STEP_W      = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int REG_RED     = 0;
  localparam int REG_GREEN   = 1;
  localparam int REG_BLUE    = 2;

  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,
    OCT_STEEP_UP     = 2'd1,
    OCT_SHALLOW_DOWN = 2'd2,
    OCT_STEEP_DOWN   = 2'd3
  } oct_t;

  typedef struct packed {
    logic [COORD_W-1:0]       x0;
    logic [COORD_W-1:0]       y0;
    oct_t                     oct;
    logic signed [STEP_W-1:0] a2;
    logic signed [STEP_W-1:0] b2;
    logic signed [DEC_W-1:0]  d0;
    logic [COORD_W-1:0]       cnt;
  } line_cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

endpackage

`default_nettype wire

[src/bresenham_line_rasterizer.sv]
// Top level of the Bresenham line rasterizer
`default_nettype none

// Takes one line request per in_ transaction and emits one out_ transaction per
// pixel, from the left endpoint to the right, carrying the color last written
// through the cfg_ port (red at 0x0, green at 0x4, blue at 0x8). Coordinates at
// or beyond IMAGE_SIZE are clamped to IMAGE_SIZE-1. A line of N pixels, N being
// max(|dx|,|dy|)+1 and at most 64, occupies the stepper while it loads the
// command and then emits its pixels, one decision update per cycle unless the
// output stalls. Requests are classified on entry and wait in a two-entry
// queue, so up to two further lines are taken while one is drawn. Write the
// color registers only while no line is in flight.

module bresenham_line_rasterizer #(
  parameter int IMAGE_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // start_x, start_y, end_x, end_y
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // pixel_x, pixel_y, pixel_red, pixel_green,
                                       // pixel_blue, zero fill
  output logic             out_tlast,  // last_pixel
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CW = brl_pkg::COORD_W;

  brl_pkg::color_t    color_r, color_nxt;
  brl_pkg::line_cmd_t front_cmd, q_cmd;
  logic               q_valid, q_ready;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic [CW-1:0]      pix_x, pix_y;
  brl_pkg::color_t    pix_color;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    color_nxt = color_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        2'(brl_pkg::REG_RED):   color_nxt.red   = cfg_pwdata[brl_pkg::COLOR_W-1:0];
        2'(brl_pkg::REG_GREEN): color_nxt.green = cfg_pwdata[brl_pkg::COLOR_W-1:0];
        2'(brl_pkg::REG_BLUE):  color_nxt.blue  = cfg_pwdata[brl_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      2'(brl_pkg::REG_RED):   cfg_prdata = {24'd0, color_r.red};
      2'(brl_pkg::REG_GREEN): cfg_prdata = {24'd0, color_r.green};
      2'(brl_pkg::REG_BLUE):  cfg_prdata = {24'd0, color_r.blue};
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= '0;
    end else begin
      color_r <= color_nxt;
    end
  end

  brl_front #(
    .IMAGE_SIZE(IMAGE_SIZE)
  ) u_front (
    .req_data(in_tdata),
    .cmd     (front_cmd)
  );

  brl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(in_tvalid),
    .wr_ready(in_tready),
    .wr_cmd  (front_cmd),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_cmd  (q_cmd)
  );

  brl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd      (q_cmd),
    .color    (color_r),
    .pix_valid(out_tvalid),
    .pix_ready(out_tready),
    .pix_x    (pix_x),
    .pix_y    (pix_y),
    .pix_color(pix_color),
    .pix_last (out_tlast)
  );

  assign out_tdata = {4'd0, pix_color.blue, pix_color.green, pix_color.red, pix_y, pix_x};

endmodule

`default_nettype wire

[src/brl_queue.sv]
// Small command queue between the classifier and the stepper
`default_nettype none

module brl_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire brl_pkg::line_cmd_t wr_cmd,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output brl_pkg::line_cmd_t     rd_cmd
);

  localparam int PTR_W = (brl_pkg::QUEUE_DEPTH > 1) ? $clog2(brl_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(brl_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(brl_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(brl_pkg::QUEUE_DEPTH - 1);

  brl_pkg::line_cmd_t mem_r [brl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

[src/brl_front.sv]
// Line request intake: clamp, order endpoints, pick octant, seed decision
`default_nettype none

module brl_front #(
  parameter int IMAGE_SIZE = 64
) (
  input  wire logic [4*brl_pkg::COORD_W-1:0] req_data,
  output brl_pkg::line_cmd_t                 cmd
);

  localparam int CW = brl_pkg::COORD_W;
  localparam int DW = brl_pkg::DEC_W;
  localparam int SW = brl_pkg::STEP_W;
  localparam int MAX_C = IMAGE_SIZE - 1;
  localparam logic [12:0]   MAX_WIDE = 13'(MAX_C);
  localparam logic [CW-1:0] MAX_NARROW = CW'(MAX_C);

  logic [CW-1:0] x1, y1, x2, y2;
  logic [CW-1:0] xs, ys, ye, xe;
  logic [CW-1:0] dx, ady;
  logic signed [CW:0] dy;
  logic signed [DW-1:0] dy_e, dx_e;
  logic steep;
  brl_pkg::oct_t oct;

  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
    logic [12:0] w;
    w = {{(13-CW){1'b0}}, v};
    return (w > MAX_WIDE) ? MAX_NARROW : v;
  endfunction

  always_comb begin
    x1 = clamp(req_data[CW-1:0]);
    y1 = clamp(req_data[2*CW-1:CW]);
    x2 = clamp(req_data[3*CW-1:2*CW]);
    y2 = clamp(req_data[4*CW-1:3*CW]);
    if (x1 > x2) begin
      xs = x2; ys = y2; xe = x1; ye = y1;
    end else begin
      xs = x1; ys = y1; xe = x2; ye = y2;
    end
    dx    = xe - xs;
    dy    = $signed({1'b0, ye}) - $signed({1'b0, ys});
    ady   = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    steep = (ady > dx);
    if (dy == '0) begin
      oct = brl_pkg::OCT_SHALLOW_UP;
    end else if (dy[CW]) begin
      oct = steep ? brl_pkg::OCT_STEEP_DOWN : brl_pkg::OCT_SHALLOW_DOWN;
    end else begin
      oct = steep ? brl_pkg::OCT_STEEP_UP : brl_pkg::OCT_SHALLOW_UP;
    end
    dy_e = DW'(dy);
    dx_e = $signed({{(DW-CW){1'b0}}, dx});

    cmd.x0  = xs;
    cmd.y0  = ys;
    cmd.oct = oct;
    cmd.a2  = SW'(dy_e <<< 1);
    cmd.b2  = SW'(-(dx_e <<< 1));
    unique case (oct)
      brl_pkg::OCT_SHALLOW_UP: begin
        cmd.d0  = (dy_e <<< 1) - dx_e;
        cmd.cnt = dx;
      end
      brl_pkg::OCT_STEEP_UP: begin
        cmd.d0  = dy_e - (dx_e <<< 1);
        cmd.cnt = ady;
      end
      brl_pkg::OCT_SHALLOW_DOWN: begin
        cmd.d0  = (dy_e <<< 1) + dx_e;
        cmd.cnt = dx;
      end
      default: begin
        cmd.d0  = dy_e + (dx_e <<< 1);
        cmd.cnt = ady;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/brl_back.sv]
// Pixel stepper with output register
`default_nettype none

module brl_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire brl_pkg::line_cmd_t cmd,
  input  wire brl_pkg::color_t    color,
  output logic                    pix_valid,
  input  wire logic               pix_ready,
  output logic [brl_pkg::COORD_W-1:0] pix_x,
  output logic [brl_pkg::COORD_W-1:0] pix_y,
  output brl_pkg::color_t         pix_color,
  output logic                    pix_last
);

  localparam int CW = brl_pkg::COORD_W;
  localparam int DW = brl_pkg::DEC_W;

  logic                 busy_r, busy_nxt;
  logic [CW-1:0]        x_r, x_nxt, y_r, y_nxt, cnt_r, cnt_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  brl_pkg::oct_t        oct_r, oct_nxt;
  logic signed [brl_pkg::STEP_W-1:0] a2_r, a2_nxt, b2_r, b2_nxt;
  logic                 vld_r, vld_nxt, last_r, last_nxt;
  logic [CW-1:0]        px_r, px_nxt, py_r, py_nxt;
  brl_pkg::color_t      col_r, col_nxt;

  logic                 out_free, load, emit, tk;
  logic signed [DW-1:0] a2e, b2e, d_step;
  logic [CW-1:0]        x_step, y_step;

  assign out_free  = !vld_r || pix_ready;
  assign load      = !busy_r && cmd_valid;
  assign emit      = busy_r && out_free;
  assign cmd_ready = !busy_r;

  assign pix_valid = vld_r;
  assign pix_x     = px_r;
  assign pix_y     = py_r;
  assign pix_color = col_r;
  assign pix_last  = last_r;

  always_comb begin
    a2e = DW'(a2_r);
    b2e = DW'(b2_r);
    unique case (oct_r)
      brl_pkg::OCT_SHALLOW_UP: begin
        tk     = (d_r > 0);
        d_step = d_r + a2e + (tk ? b2e : '0);
        x_step = x_r + CW'(1);
        y_step = tk ? y_r + CW'(1) : y_r;
      end
      brl_pkg::OCT_STEEP_UP: begin
        tk     = (d_r < 0);
        d_step = d_r + b2e + (tk ? a2e : '0);
        x_step = tk ? x_r + CW'(1) : x_r;
        y_step = y_r + CW'(1);
      end
      brl_pkg::OCT_SHALLOW_DOWN: begin
        tk     = (d_r < 0);
        d_step = d_r + a2e - (tk ? b2e : '0);
        x_step = x_r + CW'(1);
        y_step = tk ? y_r - CW'(1) : y_r;
      end
      default: begin
        tk     = (d_r > 0);
        d_step = d_r - b2e + (tk ? a2e : '0);
        x_step = tk ? x_r + CW'(1) : x_r;
        y_step = y_r - CW'(1);
      end
    endcase

    busy_nxt = busy_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    oct_nxt  = oct_r;
    a2_nxt   = a2_r;
    b2_nxt   = b2_r;
    vld_nxt  = vld_r;
    last_nxt = last_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    col_nxt  = col_r;

    if (load) begin
      busy_nxt = 1'b1;
      x_nxt    = cmd.x0;
      y_nxt    = cmd.y0;
      d_nxt    = cmd.d0;
      cnt_nxt  = cmd.cnt;
      oct_nxt  = cmd.oct;
      a2_nxt   = cmd.a2;
      b2_nxt   = cmd.b2;
    end

    if (emit) begin
      vld_nxt  = 1'b1;
      px_nxt   = x_r;
      py_nxt   = y_r;
      col_nxt  = color;
      last_nxt = (cnt_r == '0);
      busy_nxt = (cnt_r != '0);
      x_nxt    = x_step;
      y_nxt    = y_step;
      d_nxt    = d_step;
      cnt_nxt  = cnt_r - CW'(1);
    end else if (pix_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    d_r    <= d_nxt;
    cnt_r  <= cnt_nxt;
    oct_r  <= oct_nxt;
    a2_r   <= a2_nxt;
    b2_r   <= b2_nxt;
    last_r <= last_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    col_r  <= col_nxt;
  end

endmodule

`default_nettype wire

[src/brl_checker.sv]
// Port-level checker for the line rasterizer, bound to the top level
`default_nettype none

`include "bresenham_line_rasterizer_assert.svh"

module brl_checker #(
  parameter int IMAGE_SIZE = 64
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast
);

  localparam logic [12:0] IMG_LIM = 13'(IMAGE_SIZE);

  logic [5:0] pix_x, pix_y;
  logic [5:0] prev_x_r, prev_y_r;
  logic       hold_wait, beat_more, step_ok;

  assign pix_x     = out_tdata[5:0];
  assign pix_y     = out_tdata[11:6];
  assign hold_wait = out_tvalid && !out_tready;
  assign beat_more = out_tvalid && out_tready && !out_tlast;
  assign step_ok   = (pix_x == prev_x_r + 6'd1) || (pix_y == prev_y_r + 6'd1) ||
                     (pix_y == prev_y_r - 6'd1);

  always_ff @(posedge clk) begin
    prev_x_r <= pix_x;
    prev_y_r <= pix_y;
  end

  `BRL_CHECK_RST(a_out_idle_after_reset, !rst_n |=> !out_tvalid)
  `BRL_CHECK(a_out_hold, hold_wait |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `BRL_CHECK(a_pix_in_image, out_tvalid |-> ({7'd0, pix_x} < IMG_LIM) && ({7'd0, pix_y} < IMG_LIM))
  `BRL_CHECK(a_next_pix_follows, beat_more |=> out_tvalid)
  `BRL_CHECK(a_next_pix_adjacent, $past(beat_more) |-> step_ok)

endmodule

bind bresenham_line_rasterizer brl_checker #(.IMAGE_SIZE(IMAGE_SIZE)) u_brl_checker (.*);

`default_nettype wire

[dv/bresenham_line_rasterizer_tb.sv]
// Testbench for the line rasterizer: predicts pixel streams and checks every output beat
`timescale 1ns / 100ps

module bresenham_line_rasterizer_tb;

  localparam int IMG          = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 70;
  localparam int MAX_REPORTS  = 10;

  // {end_y, end_x, start_y, start_x}
  localparam logic [23:0] CORNER_LINES [20] = '{
    {6'd0,  6'd0,  6'd0,  6'd0},
    {6'd63, 6'd63, 6'd63, 6'd63},
    {6'd0,  6'd63, 6'd0,  6'd0},
    {6'd63, 6'd0,  6'd63, 6'd63},
    {6'd63, 6'd5,  6'd0,  6'd5},
    {6'd0,  6'd10, 6'd63, 6'd10},
    {6'd63, 6'd63, 6'd0,  6'd0},
    {6'd0,  6'd63, 6'd63, 6'd0},
    {6'd0,  6'd0,  6'd63, 6'd63},
    {6'd25, 6'd40, 6'd10, 6'd0},
    {6'd50, 6'd20, 6'd0,  6'd3},
    {6'd30, 6'd60, 6'd50, 6'd0},
    {6'd2,  6'd25, 6'd60, 6'd10},
    {6'd10, 6'd0,  6'd25, 6'd40},
    {6'd0,  6'd3,  6'd50, 6'd20},
    {6'd62, 6'd63, 6'd0,  6'd0},
    {6'd63, 6'd62, 6'd0,  6'd0},
    {6'd0,  6'd62, 6'd63, 6'd0},
    {6'd1,  6'd0,  6'd0,  6'd63},
    {6'd42, 6'd21, 6'd21, 6'd42}
  };

  typedef struct {
    logic [brl_pkg::COORD_W-1:0] x;
    logic [brl_pkg::COORD_W-1:0] y;
    logic [brl_pkg::COLOR_W-1:0] red;
    logic [brl_pkg::COLOR_W-1:0] green;
    logic [brl_pkg::COLOR_W-1:0] blue;
    logic                        last;
  } pixel_t;

  class pixel_scoreboard;
    brl_pkg::color_t             paint;
    pixel_t                      due_pixels[$];
    logic [brl_pkg::COORD_W-1:0] pen_x, pen_y, stop_pos;
    logic [brl_pkg::DEC_W-1:0]   dec_val;
    brl_pkg::oct_t               last_oct;
    int                          faults, lines, pixels;
    int                          oct_hits[4];

    function new();
      paint    = '0;
      pen_x    = '0;
      pen_y    = '0;
      stop_pos = '0;
      dec_val  = '0;
      last_oct = brl_pkg::OCT_SHALLOW_UP;
      faults   = 0;
      lines    = 0;
      pixels   = 0;
      oct_hits = '{0, 0, 0, 0};
    endfunction

    function void set_color(int idx, logic [brl_pkg::COLOR_W-1:0] v);
      case (idx)
        brl_pkg::REG_RED:   paint.red   = v;
        brl_pkg::REG_GREEN: paint.green = v;
        brl_pkg::REG_BLUE:  paint.blue  = v;
        default: ;
      endcase
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
    endfunction

    static function int fit(logic [brl_pkg::COORD_W-1:0] v);
      return (v > IMG - 1) ? IMG - 1 : int'(v);
    endfunction

    function void note_line(logic [23:0] word);
      int            x1, y1, x2, y2, dx, dy, a, b, d, x, y, len, stop, t;
      brl_pkg::oct_t oct;
      pixel_t        px;
      x1 = fit(word[5:0]);
      y1 = fit(word[11:6]);
      x2 = fit(word[17:12]);
      y2 = fit(word[23:18]);
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      a  = dy;
      b  = -dx;
      if (dy == 0) oct = brl_pkg::OCT_SHALLOW_UP;
      else if (dx == 0) oct = (dy > 0) ? brl_pkg::OCT_STEEP_UP : brl_pkg::OCT_STEEP_DOWN;
      else if (dy > 0) oct = (dy > dx) ? brl_pkg::OCT_STEEP_UP : brl_pkg::OCT_SHALLOW_UP;
      else oct = (-dy > dx) ? brl_pkg::OCT_STEEP_DOWN : brl_pkg::OCT_SHALLOW_DOWN;
      case (oct)
        brl_pkg::OCT_SHALLOW_UP: begin
          d = 2 * a + b; len = dx + 1; stop = x2;
        end
        brl_pkg::OCT_STEEP_UP: begin
          d = a + 2 * b; len = dy + 1; stop = y2;
        end
        brl_pkg::OCT_SHALLOW_DOWN: begin
          d = 2 * a - b; len = dx + 1; stop = x2;
        end
        default: begin
          d = a - 2 * b; len = 1 - dy; stop = y2;
        end
      endcase
      x = x1;
      y = y1;
      for (int i = 0; i < len; i++) begin
        px.x     = x[brl_pkg::COORD_W-1:0];
        px.y     = y[brl_pkg::COORD_W-1:0];
        px.red   = paint.red;
        px.green = paint.green;
        px.blue  = paint.blue;
        px.last  = (i == len - 1);
        due_pixels.push_back(px);
        case (oct)
          brl_pkg::OCT_SHALLOW_UP: begin
            if (d > 0) begin y++; d += 2 * b; end
            x++; d += 2 * a;
          end
          brl_pkg::OCT_STEEP_UP: begin
            if (d < 0) begin x++; d += 2 * a; end
            y++; d += 2 * b;
          end
          brl_pkg::OCT_SHALLOW_DOWN: begin
            if (d < 0) begin y--; d -= 2 * b; end
            x++; d += 2 * a;
          end
          default: begin
            if (d > 0) begin x++; d += 2 * a; end
            y--; d -= 2 * b;
          end
        endcase
      end
      pen_x    = x[brl_pkg::COORD_W-1:0];
      pen_y    = y[brl_pkg::COORD_W-1:0];
      dec_val  = d[brl_pkg::DEC_W-1:0];
      last_oct = oct;
      stop_pos = stop[brl_pkg::COORD_W-1:0];
      lines++;
      oct_hits[oct]++;
    endfunction

    function void check_pixel(logic [39:0] data, logic last);
      pixel_t want, got;
      got.x     = data[5:0];
      got.y     = data[11:6];
      got.red   = data[19:12];
      got.green = data[27:20];
      got.blue  = data[35:28];
      got.last  = last;
      if (due_pixels.size() == 0) begin
        fault($sformatf("pixel (%0d,%0d) with no line pending", got.x, got.y));
        return;
      end
      want = due_pixels.pop_front();
      pixels++;
      if (got.x !== want.x || got.y !== want.y || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue || got.last !== want.last)
        fault($sformatf("exp (%0d,%0d) rgb %h %h %h last %b, got (%0d,%0d) rgb %h %h %h last %b",
                        want.x, want.y, want.red, want.green, want.blue, want.last,
                        got.x, got.y, got.red, got.green, got.blue, got.last));
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [23:0] in_tdata    = '0;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [39:0] out_tdata;
  wire         out_tlast;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  pixel_scoreboard board = new();

  bresenham_line_rasterizer #(.IMAGE_SIZE(IMG)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) board.check_pixel(out_tdata, out_tlast);
  end

  function automatic int keep_on_image(int v);
    return (v < 0) ? 0 : ((v > IMG - 1) ? IMG - 1 : v);
  endfunction

  // mostly short lines, some anywhere, some horizontal/vertical/diagonal/point
  function automatic logic [23:0] rand_line();
    int sx, sy, ex, ey, pick, k;
    sx   = $urandom_range(IMG - 1);
    sy   = $urandom_range(IMG - 1);
    ex   = $urandom_range(IMG - 1);
    ey   = $urandom_range(IMG - 1);
    pick = $urandom_range(99);
    if (pick < 55) begin
      ex = keep_on_image(sx + int'($urandom_range(14)) - 7);
      ey = keep_on_image(sy + int'($urandom_range(14)) - 7);
    end else if (pick >= 85) begin
      k = int'($urandom_range(IMG - 1)) - sx;
      case ($urandom_range(3))
        0: ey = sy;
        1: ex = sx;
        2: begin
          ex = sx + k;
          ey = keep_on_image(($urandom_range(1) != 0) ? sy + k : sy - k);
        end
        default: begin
          ex = sx;
          ey = sy;
        end
      endcase
    end
    return {ey[5:0], ex[5:0], sy[5:0], sx[5:0]};
  endfunction

  task automatic send_line(input logic [23:0] word);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_line(word);
  endtask

  task automatic write_color(input int idx, input logic [brl_pkg::COLOR_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 4'(4 * idx);
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.set_color(idx, val);
    // read back, psel held for the next setup
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== 32'(val))
      board.fault($sformatf("reg %0d read %h, wrote %h", idx, cfg_prdata, val));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic begin_segment(input int gap_pct, input int stall_pct,
                               input logic [brl_pkg::COLOR_W-1:0] r,
                               input logic [brl_pkg::COLOR_W-1:0] g,
                               input logic [brl_pkg::COLOR_W-1:0] b);
    write_color(brl_pkg::REG_RED, r);
    write_color(brl_pkg::REG_GREEN, g);
    write_color(brl_pkg::REG_BLUE, b);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    while (board.due_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    begin_segment(16, 83, 8'hFF, 8'h00, 8'hA5);
    foreach (CORNER_LINES[i]) send_line(CORNER_LINES[i]);
    repeat (150) send_line(rand_line());
    drain_pixels();

    begin_segment(83, 16, 8'h00, 8'hFF, 8'h5A);
    repeat (150) send_line(rand_line());
    drain_pixels();

    begin_segment(0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    repeat (76) send_line(rand_line());
    drain_pixels();

    begin_segment(0, 0, 8'hFF, 8'hFF, 8'hFF);
    repeat (76) send_line(rand_line());
    drain_pixels();

    if (board.due_pixels.size() != 0)
      board.fault($sformatf("%0d pixels never arrived", board.due_pixels.size()));
    $display("Covered %0d lines (octants %0d/%0d/%0d/%0d), %0d pixels, four color settings",
             board.lines, board.oct_hits[0], board.oct_hits[1], board.oct_hits[2],
             board.oct_hits[3], board.pixels);
    $display("Idling mixes: slow sink, slow source, none; %0d faults", board.faults);
    if (board.faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
